// ===== sv/nvse_pkg.sv =====
// Shared types and constants for the numeric value string encoder.
package nvse_pkg;

    // Parse phases, one-hot.
    typedef enum logic [5:0] {
        PH_START = 6'b000001,
        PH_LEAD  = 6'b000010,
        PH_NUM   = 6'b000100,
        PH_DEN0  = 6'b001000,
        PH_DEN   = 6'b010000,
        PH_LARGE = 6'b100000
    } phase_t;

    // Parse state; the finish logic classifies a copy of it taken after the last character.
    typedef struct packed {
        phase_t      phase;
        logic        neg;
        logic [30:0] num;
        logic [30:0] den;
        logic        ovf;
        logic        stray;
        logic [3:0]  sig;
        logic        multi;
        logic        lead_nz;
        logic [5:0]  tz;
    } parse_st_t;

    localparam parse_st_t PARSE_RESET = '{
        phase:   PH_START,
        neg:     1'b0,
        num:     31'd0,
        den:     31'd0,
        ovf:     1'b0,
        stray:   1'b0,
        sig:     4'd0,
        multi:   1'b0,
        lead_nz: 1'b0,
        tz:      6'd0
    };

    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_NINE  = 8'h39;
    localparam logic [7:0] CH_MINUS = 8'h2d;
    localparam logic [7:0] CH_SLASH = 8'h2f;

    localparam logic [30:0] MAX31  = 31'h7fffffff;
    localparam logic [5:0]  TZ_MAX = 6'd63;

endpackage

// ===== sv/nvse_in_if.sv =====
// Character channel: one text character per word.
interface nvse_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;
    logic       last_char;

    modport source (output valid, output char_code, output last_char, input ready);
    modport sink (input valid, input char_code, input last_char, output ready);
endinterface

// ===== sv/nvse_out_if.sv =====
// Result channel: one numeric code and error flag per word.
interface nvse_out_if;
    logic       valid;
    logic       ready;
    logic [9:0] numeric_code;
    logic       bad_value;

    modport source (output valid, output numeric_code, output bad_value, input ready);
    modport sink (input valid, input numeric_code, input bad_value, output ready);
endinterface

// ===== sv/numeric_value_string_encoder.sv =====
// Top level of the numeric value string encoder.
//
// The chars channel takes one ASCII character of a decimal numeric text per
// word: an optional minus sign, digits, and an optional slash with a
// denominator; last_char marks the final character of a text. After the last
// character the codes channel gives one word with the 10-bit numeric code and
// the bad_value error flag; other characters give no word.
// Each accepted character passes an input register, the parse state update
// and, for the last character, a captured copy of the parse state and the
// result register. One character is taken every cycle unless a final
// character waits for room for its result; the rate is set by the single
// parse state update per character.
// Reset clears all valid flags and returns the parser to the start of a text.
// When the receiver stalls, a finished result waits in the output register
// while one more finished text and further characters are still taken; the
// chars channel deasserts ready only once those stages are full.
module numeric_value_string_encoder (
    input  logic       clk,
    input  logic       rst_n,
    nvse_in_if.sink    chars,
    nvse_out_if.source codes
);
    import nvse_pkg::*;

    logic       inr_valid_reg;
    logic       inr_valid_next;
    logic [7:0] inr_char_reg;
    logic       inr_last_reg;
    logic       fin_valid_reg;
    logic       fin_valid_next;
    parse_st_t  fin_reg;
    logic       out_valid_reg;
    logic       out_valid_next;
    logic [9:0] code_reg;
    logic       bad_reg;

    logic       in_take;
    logic       inr_adv;
    logic       out_free;
    logic       fin_free;
    logic       fin_move;
    parse_st_t  post;
    logic [9:0] fin_code;
    logic       fin_bad;

    assign out_free    = !out_valid_reg || codes.ready;
    assign fin_free    = !fin_valid_reg || out_free;
    assign fin_move    = fin_valid_reg && out_free;
    // A non-final character never waits; the final one needs room for its result.
    assign inr_adv     = inr_valid_reg && (!inr_last_reg || fin_free);
    assign chars.ready = !inr_valid_reg || inr_adv;
    assign in_take     = chars.valid && chars.ready;

    nvse_parse u_parse (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (inr_adv),
        .char_code (inr_char_reg),
        .last_char (inr_last_reg),
        .post      (post)
    );

    nvse_finish u_finish (
        .st           (fin_reg),
        .numeric_code (fin_code),
        .bad_value    (fin_bad)
    );

    always_comb
    begin
        inr_valid_next = in_take || (inr_valid_reg && !inr_adv);
        fin_valid_next = (inr_adv && inr_last_reg) || (fin_valid_reg && !out_free);
        out_valid_next = fin_move || (out_valid_reg && !codes.ready);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inr_valid_reg <= 1'b0;
            fin_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            inr_valid_reg <= inr_valid_next;
            fin_valid_reg <= fin_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            inr_char_reg <= chars.char_code;
            inr_last_reg <= chars.last_char;
        end
        if (inr_adv && inr_last_reg)
        begin
            fin_reg <= post;
        end
        if (fin_move)
        begin
            code_reg <= fin_code;
            bad_reg  <= fin_bad;
        end
    end

    assign codes.valid        = out_valid_reg;
    assign codes.numeric_code = code_reg;
    assign codes.bad_value    = bad_reg;

endmodule

// ===== sv/nvse_parse.sv =====
// Character-by-character parse state of the numeric text.
module nvse_parse (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 step,
    input  logic [7:0]           char_code,
    input  logic                 last_char,
    output nvse_pkg::parse_st_t  post
);
    import nvse_pkg::*;

    parse_st_t   state_reg;
    parse_st_t   state_next;
    logic        dig;
    logic [3:0]  d;
    logic [31:0] num_step;
    logic [31:0] den_step;
    logic [5:0]  tz_inc;

    // Multiply by ten and add a digit, saturating at 2^31-1; bit 31 flags overflow.
    function automatic logic [31:0] acc10(input logic [30:0] acc, input logic [3:0] dv);
        logic [34:0] t;
        begin
            t = ({4'd0, acc} << 3) + ({4'd0, acc} << 1) + {31'd0, dv};
            if (t > {4'd0, MAX31})
            begin
                acc10 = {1'b1, MAX31};
            end
            else
            begin
                acc10 = {1'b0, t[30:0]};
            end
        end
    endfunction

    assign dig      = (char_code >= CH_ZERO) && (char_code <= CH_NINE);
    assign d        = dig ? 4'(char_code - CH_ZERO) : 4'd0;
    assign num_step = acc10(state_reg.num, d);
    assign den_step = acc10(state_reg.den, d);
    assign tz_inc   = (state_reg.tz == TZ_MAX) ? state_reg.tz : state_reg.tz + 6'd1;

    always_comb
    begin
        state_next = state_reg;
        if (!state_reg.stray)
        begin
            unique case (state_reg.phase)
                PH_START, PH_LEAD:
                begin
                    if (dig)
                    begin
                        state_next.phase   = PH_NUM;
                        state_next.num     = {27'd0, d};
                        state_next.sig     = d;
                        state_next.lead_nz = (d != 4'd0);
                        state_next.multi   = 1'b0;
                        state_next.tz      = 6'd0;
                    end
                    else if (state_reg.phase == PH_START && char_code == CH_MINUS)
                    begin
                        state_next.neg   = 1'b1;
                        state_next.phase = PH_LEAD;
                    end
                    else
                    begin
                        state_next.stray = 1'b1;
                    end
                end
                PH_NUM:
                begin
                    if (dig)
                    begin
                        state_next.num = num_step[30:0];
                        state_next.ovf = state_reg.ovf | num_step[31];
                        if (d != 4'd0)
                        begin
                            if (state_reg.sig == 4'd0)
                            begin
                                state_next.sig = d;
                            end
                            else
                            begin
                                state_next.multi = 1'b1;
                            end
                            state_next.tz = 6'd0;
                        end
                        else if (state_reg.sig != 4'd0)
                        begin
                            state_next.tz = tz_inc;
                            // A nonzero lead digit followed by two zeros switches to the
                            // large form, where only zeros may follow.
                            if (state_reg.lead_nz && !state_reg.multi && tz_inc >= 6'd2)
                            begin
                                state_next.phase = PH_LARGE;
                            end
                        end
                    end
                    else if (char_code == CH_SLASH)
                    begin
                        state_next.phase = PH_DEN0;
                    end
                    else
                    begin
                        state_next.stray = 1'b1;
                    end
                end
                PH_DEN0:
                begin
                    if (dig)
                    begin
                        state_next.phase = PH_DEN;
                        state_next.den   = {27'd0, d};
                    end
                    else
                    begin
                        state_next.stray = 1'b1;
                    end
                end
                PH_DEN:
                begin
                    if (dig)
                    begin
                        state_next.den = den_step[30:0];
                        state_next.ovf = state_reg.ovf | den_step[31];
                    end
                    else
                    begin
                        state_next.stray = 1'b1;
                    end
                end
                PH_LARGE:
                begin
                    if (char_code == CH_ZERO)
                    begin
                        state_next.tz = tz_inc;
                    end
                    else
                    begin
                        state_next.stray = 1'b1;
                    end
                end
                default:
                begin
                    state_next.stray = 1'b1;
                end
            endcase
        end
    end

    assign post = state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= PARSE_RESET;
        end
        else if (step)
        begin
            state_reg <= last_char ? PARSE_RESET : state_next;
        end
    end

endmodule

// ===== sv/nvse_finish.sv =====
// Classification of a completed parse into the numeric code and error flag.
module nvse_finish (
    input  nvse_pkg::parse_st_t st,
    output logic [9:0]          numeric_code,
    output logic                bad_value
);
    import nvse_pkg::*;

    localparam logic [30:0] SMALL_MAX  = 31'd154;
    localparam logic [9:0]  SMALL_BASE = 10'd21;
    localparam logic [9:0]  CODE_100   = 10'd121;

    logic       err;
    logic [3:0] den_m1;

    function automatic logic [9:0] large_code(input logic [3:0] m, input logic [5:0] e);
        begin
            large_code = (({6'd0, m} + 10'd14) << 5) + ({4'd0, e} - 10'd2);
        end
    endfunction

    assign err = st.stray || st.ovf || (st.phase == PH_DEN0) ||
                 (st.phase == PH_DEN && st.den == 31'd0);
    assign den_m1 = 4'(st.den - 31'd1);

    always_comb
    begin
        numeric_code = 10'd0;
        if (!err)
        begin
            if (st.phase == PH_LARGE)
            begin
                if (!st.neg)
                begin
                    if (st.tz == 6'd2 && st.sig == 4'd1)
                    begin
                        numeric_code = CODE_100;
                    end
                    else if (st.tz >= 6'd2 && st.tz <= 6'd33)
                    begin
                        numeric_code = large_code(st.sig, st.tz);
                    end
                end
            end
            else if (st.phase == PH_DEN)
            begin
                if (st.den >= 31'd1 && st.den <= 31'd16)
                begin
                    if (st.neg)
                    begin
                        if (st.num <= 31'd1)
                        begin
                            numeric_code = {2'b00, 4'd12 - {3'd0, st.num[0]}, den_m1};
                        end
                    end
                    else if (st.num <= 31'd17)
                    begin
                        numeric_code = {1'b0, 5'(st.num[4:0] + 5'd12), den_m1};
                    end
                end
            end
            else if (!(st.neg && st.num != 31'd0))
            begin
                if (st.num <= SMALL_MAX)
                begin
                    numeric_code = SMALL_BASE + st.num[9:0];
                end
                // One significant digit followed by at least two zeros.
                else if (st.sig != 4'd0 && !st.multi && st.tz >= 6'd2)
                begin
                    numeric_code = large_code(st.sig, st.tz);
                end
            end
        end
    end

    assign bad_value = err;

endmodule
